// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// ===== design/slt_pkg.sv =====
package slt_pkg;

  localparam int CAPACITY    = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int COUNT_W     = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_DUMP   = 2'd3
  } op_e;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FOUND    = 3'd4;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] element;
    logic [COUNT_W-1:0] count;
    logic               last;
  } out_item_t;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] held;
    logic             idle;
  } back_stat_t;

endpackage

// ===== design/slt_front.sv =====
module slt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  slt_pkg::in_item_t item_i,
  output logic              busy_o,
  output logic              cmd_valid_o,
  output slt_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);

  slt_pkg::cmd_t                 q_mem [slt_pkg::QUEUE_DEPTH];
  logic [slt_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [slt_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [slt_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  logic                          push, pop;
  slt_pkg::cmd_t                 cmd_in;

  // decode the operation code into the command kind
  always_comb begin
    cmd_in.op    = slt_pkg::op_e'(item_i.operation);
    cmd_in.value = item_i.value;
  end

  assign busy_o      = (cnt_q == slt_pkg::QCNT_W'(slt_pkg::QUEUE_DEPTH));
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== design/slt_back.sv =====
module slt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  slt_pkg::cmd_t       cmd_i,
  output logic                cmd_pop_o,
  output logic                done_o,
  output slt_pkg::out_item_t  result_o,
  output slt_pkg::back_stat_t stat_o
);

  localparam int CAP = slt_pkg::CAPACITY;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DEL  = 3'b010,
    S_DUMP = 3'b100
  } state_e;

  state_e                     state_q, state_d;
  logic signed [31:0]         ent_q [CAP];
  logic [slt_pkg::CNT_W-1:0]  held_q, held_d;
  logic [slt_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic signed [31:0]         val_q, val_d;
  logic                       removed_q, removed_d;
  logic                       done_q, done_d;
  slt_pkg::out_item_t         res_q, res_d;

  logic signed [31:0]         cmp_val;
  logic [CAP-1:0]             valid, gt, ge, eq, prev_gt, place;
  logic signed [31:0]         ins_ent [CAP];
  logic signed [31:0]         del_ent [CAP];
  logic signed [31:0]         nxt_ent [CAP];
  logic                       hit, ins_we, del_we, dump_last;

  assign cmp_val = (state_q == S_DEL) ? val_q : cmd_i.value;

  // compare-and-shift cells, one per entry
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      valid[i] = slt_pkg::CNT_W'(i) < held_q;
      gt[i]    = valid[i] && (ent_q[i] > cmp_val);
      ge[i]    = valid[i] && (ent_q[i] >= cmp_val);
      eq[i]    = valid[i] && (ent_q[i] == cmp_val);
      place[i] = valid[i] ? gt[i] : (slt_pkg::CNT_W'(i) == held_q);
    end
    prev_gt[0]       = 1'b0;
    nxt_ent[CAP-1]   = ent_q[CAP-1];
    for (int i = 1; i < CAP; i++) begin
      prev_gt[i]   = gt[i-1];
      nxt_ent[i-1] = ent_q[i];
    end
    ins_ent[0] = place[0] ? cmp_val : ent_q[0];
    for (int i = 1; i < CAP; i++) begin
      ins_ent[i] = place[i] ? (prev_gt[i] ? ent_q[i-1] : cmp_val) : ent_q[i];
    end
    // equal entries are contiguous: dropping the first one shifts the tail left
    for (int i = 0; i < CAP; i++) begin
      del_ent[i] = ge[i] ? nxt_ent[i] : ent_q[i];
    end
  end

  assign hit       = |eq;
  assign dump_last = (slt_pkg::CNT_W'(idx_q) == held_q - slt_pkg::CNT_W'(1));

  always_comb begin
    state_d   = state_q;
    held_d    = held_q;
    idx_d     = idx_q;
    val_d     = val_q;
    removed_d = removed_q;
    done_d    = 1'b0;
    res_d     = res_q;
    ins_we    = 1'b0;
    del_we    = 1'b0;
    cmd_pop_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o     = 1'b1;
          res_d.element = '0;
          res_d.last    = 1'b1;
          res_d.count   = slt_pkg::COUNT_W'(held_q);
          case (cmd_i.op)
            slt_pkg::OP_INSERT: begin
              done_d = 1'b1;
              if (held_q == slt_pkg::CNT_W'(CAP)) begin
                res_d.status = slt_pkg::ST_FULL;
              end else begin
                ins_we       = 1'b1;
                held_d       = held_q + 1'b1;
                res_d.status = slt_pkg::ST_OK;
                res_d.count  = slt_pkg::COUNT_W'(held_q + 1'b1);
              end
            end
            slt_pkg::OP_DELETE: begin
              if (held_q == '0) begin
                done_d       = 1'b1;
                res_d.status = slt_pkg::ST_EMPTY;
              end else begin
                val_d     = cmd_i.value;
                removed_d = 1'b0;
                state_d   = S_DEL;
              end
            end
            slt_pkg::OP_FIND: begin
              done_d       = 1'b1;
              res_d.status = hit ? slt_pkg::ST_FOUND : slt_pkg::ST_NOTFOUND;
            end
            slt_pkg::OP_DUMP: begin
              if (held_q == '0) begin
                done_d       = 1'b1;
                res_d.status = slt_pkg::ST_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEL: begin
        if (hit) begin
          del_we    = 1'b1;
          held_d    = held_q - 1'b1;
          removed_d = 1'b1;
        end else begin
          done_d        = 1'b1;
          res_d.status  = removed_q ? slt_pkg::ST_OK : slt_pkg::ST_NOTFOUND;
          res_d.element = '0;
          res_d.count   = slt_pkg::COUNT_W'(held_q);
          res_d.last    = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_DUMP: begin
        done_d        = 1'b1;
        res_d.status  = slt_pkg::ST_OK;
        res_d.element = ent_q[idx_q];
        res_d.count   = slt_pkg::COUNT_W'(held_q);
        res_d.last    = dump_last;
        if (dump_last) begin
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      held_q    <= '0;
      idx_q     <= '0;
      removed_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      idx_q     <= idx_d;
      removed_q <= removed_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    res_q <= res_d;
    for (int i = 0; i < CAP; i++) begin
      if (ins_we) begin
        ent_q[i] <= ins_ent[i];
      end else if (del_we) begin
        ent_q[i] <= del_ent[i];
      end
    end
  end

  assign done_o      = done_q;
  assign result_o    = res_q;
  assign stat_o.held = held_q;
  assign stat_o.idle = (state_q == S_IDLE);

endmodule

// ===== design/sorted_list_table.sv =====
// When the table is idle, an accepted item passes through the command queue to the back end's result register.
// Insert and find complete in the back end's idle state, sustaining one item per cycle.
// Delete drops matches in S_DEL until none remain; dump emits the held entries in S_DUMP.
// A 2-deep command queue decouples intake from execution; busy_o is high while it is full.
// Results cannot be stalled. Reset clears the count, queue and sequencer; entries stay.
`include "assert_macros.svh"

module sorted_list_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  slt_pkg::in_item_t  item_i,
  output logic               busy_o,
  output logic               done_o,
  output slt_pkg::out_item_t result_o
);

  logic                cmd_valid;
  logic                cmd_pop;
  slt_pkg::cmd_t       cmd;
  slt_pkg::back_stat_t stat;

  slt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .busy_o      (busy_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  slt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .done_o      (done_o),
    .result_o    (result_o),
    .stat_o      (stat)
  );

  `ASSERT_NEVER(a_held_range, clk_i, rst_ni, stat.held > slt_pkg::CNT_W'(slt_pkg::CAPACITY))
  `ASSERT_PROP(a_dump_cont, clk_i, rst_ni, (done_o && !result_o.last) |=> done_o)
  `ASSERT_PROP(a_mid_ok, clk_i, rst_ni, (done_o && !result_o.last) |-> (result_o.status == slt_pkg::ST_OK))
  `ASSERT_PROP(a_pop_idle, clk_i, rst_ni, cmd_pop |-> (stat.idle && cmd_valid))

endmodule
